// ----- design/pdre_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pixel delta/run chunk encoder: chunk opcodes, job type and queue sizing.
// Used by pdre_front, pdre_queue, pdre_back and pixel_delta_run_encoder. No dependencies.
package pdre_pkg;

    localparam logic [7:0] OP_RUN  = 8'h00;
    localparam logic [7:0] OP_RAW  = 8'h01;
    localparam logic [7:0] OP_DIFF = 8'h02;
    localparam logic [7:0] OP_LUMA = 8'h03;

    localparam logic [7:0] RUN_MAX = 8'd255;

    localparam int JOB_BYTES   = 9;
    localparam int RUN_BYTES   = 5;
    localparam int MAIN_BYTES  = 4;
    localparam int QUEUE_DEPTH = 2;

    // All bytes that one pixel causes, in send order, and how many of them count.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [3:0]                count;
    } job_t;

endpackage

// ----- design/pixel_delta_run_encoder.sv -----
`timescale 1ns / 1ps
// Pixel delta/run chunk encoder, top level. Instantiates pdre_front, pdre_queue and
// pdre_back; depends on pdre_pkg.
//
// One RGB888 pixel per input transaction goes in, one chunk-stream byte per output
// transaction comes out, and last_of_item marks the final byte a pixel caused (a pixel
// that only extends a run causes none). The front end takes a pixel in every cycle in
// which the two-entry job queue has room and turns it into a job of 0 to 9 bytes in the
// same cycle; the back end sends one byte per cycle, while the output is not stalled,
// through a registered output stage. The byte-wide output sets the sustained rate: a
// pixel causes 2 bytes for DIFF, 3 for LUMA, 4 for RAW, plus 5 when a run is flushed
// with it, and a run of repeated pixels is taken at one pixel per cycle while the queue
// has room. Jobs pass the queue, the back end's job register and the output register.
module pixel_delta_run_encoder
    import pdre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       end_of_image,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_item
);

    logic q_ready;
    logic push;
    job_t push_job;
    logic pop;
    logic pop_valid;
    job_t pop_job;

    // Classify the pixel and build its byte job.
    pdre_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_image (end_of_image),
        .q_ready      (q_ready),
        .push         (push),
        .push_job     (push_job)
    );

    // Hold jobs so either side can stall on its own.
    pdre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .ready     (q_ready),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    // Serialize job bytes onto the output channel.
    pdre_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (pop_valid),
        .q_job        (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item)
    );

endmodule

// ----- design/pdre_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks previous pixel and run state, classifies each pixel
// and builds the byte job for it. Depends on pdre_pkg.
module pdre_front
    import pdre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       end_of_image,
    input  logic       q_ready,
    output logic       push,
    output job_t       push_job
);

    logic [23:0] prev_reg, prev_next;
    logic [7:0]  run_reg, run_next;
    logic        first_reg, first_next;

    logic              accept;
    logic [23:0]       cur;
    logic              same;
    logic [7:0]        run_inc;
    logic              emit_run;
    logic [7:0]        run_val;
    logic signed [8:0] dr, dg, db;
    logic signed [9:0] drg, dbg;
    logic              is_diff, is_luma;
    logic [7:0]        main_b [MAIN_BYTES];
    logic [2:0]        main_len;
    logic [7:0]        run_b [RUN_BYTES];
    logic [7:0]        diff_byte, luma_byte;

    assign accept   = in_valid && q_ready;
    assign in_stall = !q_ready;
    assign cur      = {red, green, blue};
    assign same     = (cur == prev_reg);
    assign run_inc  = run_reg + 8'd1;

    assign dr  = $signed({1'b0, red})   - $signed({1'b0, prev_reg[23:16]});
    assign dg  = $signed({1'b0, green}) - $signed({1'b0, prev_reg[15:8]});
    assign db  = $signed({1'b0, blue})  - $signed({1'b0, prev_reg[7:0]});
    assign drg = $signed({dr[8], dr}) - $signed({dg[8], dg});
    assign dbg = $signed({db[8], db}) - $signed({dg[8], dg});

    assign is_diff = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1)
                  && (db >= -9'sd2) && (db <= 9'sd1);
    assign is_luma = (dg >= -9'sd32) && (dg <= 9'sd31) && (drg >= -10'sd8)
                  && (drg <= 10'sd7) && (dbg >= -10'sd8) && (dbg <= 10'sd7);

    assign diff_byte = {2'b00, 2'(dr + 9'sd2), 2'(dg + 9'sd2), 2'(db + 9'sd2)};
    assign luma_byte = {4'(drg + 10'sd8), 4'(dbg + 10'sd8)};

    // A run chunk always precedes the pixel's own chunk, if both occur.
    always_comb
    begin
        emit_run = !first_reg && ((same && ((run_inc == RUN_MAX) || end_of_image))
                                  || (!same && (run_reg != 8'd0)));
        run_val  = same ? run_inc : run_reg;
        run_b[0] = OP_RUN;
        run_b[1] = run_val;
        run_b[2] = prev_reg[23:16];
        run_b[3] = prev_reg[15:8];
        run_b[4] = prev_reg[7:0];

        main_b[0] = OP_RAW;
        main_b[1] = red;
        main_b[2] = green;
        main_b[3] = blue;
        main_len  = 3'd4;
        if (!first_reg && same)
        begin
            main_len = 3'd0;
        end
        else if (!first_reg && is_diff)
        begin
            main_b[0] = OP_DIFF;
            main_b[1] = diff_byte;
            main_len  = 3'd2;
        end
        else if (!first_reg && is_luma)
        begin
            main_b[0] = OP_LUMA;
            main_b[1] = 8'(dg + 9'sd32);
            main_b[2] = luma_byte;
            main_len  = 3'd3;
        end
    end

    always_comb
    begin
        push_job.bytes = '0;
        if (emit_run)
        begin
            for (int i = 0; i < RUN_BYTES; i++)
            begin
                push_job.bytes[i] = run_b[i];
            end
            for (int i = 0; i < MAIN_BYTES; i++)
            begin
                push_job.bytes[i + RUN_BYTES] = main_b[i];
            end
        end
        else
        begin
            for (int i = 0; i < MAIN_BYTES; i++)
            begin
                push_job.bytes[i] = main_b[i];
            end
        end
        push_job.count = (emit_run ? 4'(RUN_BYTES) : 4'd0) + {1'b0, main_len};
    end

    assign push = accept && (push_job.count != 4'd0);

    // Advance pixel state on every accepted transaction.
    always_comb
    begin
        prev_next  = prev_reg;
        run_next   = run_reg;
        first_next = first_reg;
        if (accept)
        begin
            prev_next  = cur;
            run_next   = (!first_reg && same && !emit_run) ? run_inc : 8'd0;
            first_next = end_of_image;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            run_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            prev_reg  <= prev_next;
            run_reg   <= run_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- design/pdre_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the byte serializer.
// Depends on pdre_pkg.
module pdre_queue
    import pdre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic ready,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready     = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (ready || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- design/pdre_back.sv -----
`timescale 1ns / 1ps
// Back end: takes jobs from the queue and sends their bytes one per cycle while the
// output is not stalled, through a registered output stage. Depends on pdre_pkg.
module pdre_back
    import pdre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_item
);

    job_t       cur_reg, cur_next;
    logic [3:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic out_load;
    logic advance;
    logic job_done;

    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = out_load && busy_reg;
    assign job_done = advance && (idx_reg == cur_reg.count - 4'd1);
    assign pop      = q_valid && (!busy_reg || job_done);

    always_comb
    begin
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = busy_reg;
            out_byte_next  = cur_reg.bytes[idx_reg];
            out_last_next  = job_done;
        end
        if (advance)
        begin
            idx_next = idx_reg + 4'd1;
        end
        if (job_done)
        begin
            busy_next = 1'b0;
        end
        // Load the next job when idle or as soon as the current one hands off its last byte.
        if (pop)
        begin
            cur_next  = q_job;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_item = out_last_reg;

`ifndef ASSERT_OFF
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cur_reg.count))
        else $error("byte index past end of job");
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_reg.count >= 4'd2))
        else $error("job shorter than any chunk");
`endif

endmodule
